>>> rtl/hac_pkg.sv
// Shared types and constants for the hit-accumulation clutter filter.
// Depends on nothing; every other file in rtl/ imports it.
package hac_pkg;

  localparam int unsigned CELL_COUNT  = 262144;
  localparam int unsigned COUNT_WIDTH = 16;
  localparam int unsigned ADDR_W      = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

  localparam int unsigned CELL_W   = 18;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned THR_W    = 15;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned PROD_W   = THR_W + COUNT_WIDTH;

  // 100 percent in Q8, the scale of the hit percentage.
  localparam logic [THR_W-1:0] PERCENT_Q8 = THR_W'(25600);
  localparam logic [THR_W-1:0] THR_RESET  = THR_W'(25600);
  localparam logic [SAMPLE_W-1:0] NODATA_RESET = SAMPLE_W'(255);

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [ADDR_W-1:0]      addr_t;

  typedef enum logic [1:0] {
    FUNC_SCAN   = 2'd0,
    FUNC_ACCUM  = 2'd1,
    FUNC_FILTER = 2'd2
  } func_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_NODATA    = 2'd1
  } cfg_reg_t;

  typedef enum logic {
    MEM_CLEAR,
    MEM_RUN
  } mem_state_t;

  // Counter write request from the pipeline to the counter memory.
  typedef struct packed {
    logic   en;
    addr_t  addr;
    count_t data;
  } mem_wr_t;

endpackage

>>> rtl/hac_count_mem.sv
// Hit counter memory: one synchronous RAM, a clearing sweep after reset,
// and forwarding of a write that lands in the same cycle as a read. Uses hac_pkg.
module hac_count_mem (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  hac_pkg::addr_t   rd_addr,
  output hac_pkg::count_t  rd_data,
  input  hac_pkg::mem_wr_t wr,
  output logic             ready
);
  import hac_pkg::*;

  count_t     ram [CELL_COUNT];
  count_t     ram_q;
  logic       fwd_hit;
  count_t     fwd_data;
  mem_state_t state;
  mem_state_t state_next;
  addr_t      clr_addr;
  addr_t      clr_addr_next;
  logic       we;
  addr_t      waddr;
  count_t     wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= MEM_CLEAR;
      clr_addr <= '0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
    end
  end

  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    ready         = 1'b0;
    we            = wr.en;
    waddr         = wr.addr;
    wdata         = wr.data;
    unique case (state)
      MEM_CLEAR: begin
        we            = 1'b1;
        waddr         = clr_addr;
        wdata         = '0;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == ADDR_W'(CELL_COUNT - 1)) begin
          state_next = MEM_RUN;
        end
      end
      MEM_RUN: begin
        ready = 1'b1;
      end
      default: begin
        state_next = MEM_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      ram[waddr] <= wdata;
    end
    if (rd_en) begin
      ram_q <= ram[rd_addr];
    end
  end

  // The RAM returns old data when read and write hit one entry at one edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (rd_en) begin
      fwd_hit <= wr.en && (wr.addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data <= wr.data;
    end
  end

  assign rd_data = fwd_hit ? fwd_data : ram_q;

endmodule

>>> rtl/hac_clutter_test.sv
// Clutter decision: 25600 x hits against threshold x scans, without division.
// Uses hac_pkg.
module hac_clutter_test (
  input  hac_pkg::count_t              hits,
  input  hac_pkg::count_t              scans,
  input  logic [hac_pkg::THR_W-1:0]    threshold,
  input  logic                         is_data,
  output logic                         clutter
);
  import hac_pkg::*;

  logic [PROD_W-1:0] lhs;
  logic [PROD_W-1:0] rhs;

  assign lhs = {{COUNT_WIDTH{1'b0}}, PERCENT_Q8} * {{THR_W{1'b0}}, hits};
  assign rhs = {{COUNT_WIDTH{1'b0}}, threshold} * {{THR_W{1'b0}}, scans};

  // With no scans accumulated nothing counts as clutter.
  assign clutter = is_data && (scans != '0) && (lhs > rhs);

endmodule

>>> rtl/hit_accumulation_clutter_filter.sv
// Top level of the hit-accumulation clutter filter: two-stage item pipeline,
// configuration registers and output register. Uses hac_pkg, hac_count_mem
// and hac_clutter_test.
//
//   Channel  Direction  Handshake            Contents
//   in       input      in_valid/in_stall    func, cell_index, sample_is_data, sample_value
//   out      output     out_valid/out_stall  out_value, removed, quality_value
//   cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item is taken per cycle while in_stall is low. The counter RAM is read at
// the edge that accepts the item into the second stage; the read-modify-write of
// the counter or the multiply-and-compare test is done from that stage, and its
// result is loaded into the output register when the stage advances.
// After reset the counter RAM is swept to zero, one entry per cycle, and in_stall
// stays high until the sweep has ended.
// When the output register is full and stalled, the item in the second
// stage waits and in_stall rises; the cfg channel is always ready.
module hit_accumulation_clutter_filter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      func,
  input  logic [hac_pkg::CELL_W-1:0]      cell_index,
  input  logic                            sample_is_data,
  input  logic [hac_pkg::SAMPLE_W-1:0]    sample_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [hac_pkg::SAMPLE_W-1:0]    out_value,
  output logic                            removed,
  output logic [hac_pkg::SAMPLE_W-1:0]    quality_value,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hac_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hac_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import hac_pkg::*;

  // Configuration registers.
  logic [THR_W-1:0]    hit_threshold_q8;
  logic [SAMPLE_W-1:0] nodata_value;

  // Scan counter, saturating.
  count_t scan_count;

  // Second pipeline stage: the item whose counter is being read.
  logic                s1_valid;
  logic [1:0]          s1_func;
  addr_t               s1_addr;
  logic                s1_in_range;
  logic                s1_is_data;
  logic [SAMPLE_W-1:0] s1_sample;

  logic    accept;
  logic    advance;
  logic    mem_ready;
  count_t  mem_rd_data;
  mem_wr_t mem_wr;
  count_t  hits;
  logic    clutter;
  logic    in_range;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_threshold_q8 <= THR_RESET;
      nodata_value     <= NODATA_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_THRESHOLD) begin
        hit_threshold_q8 <= cfg_data[THR_W-1:0];
      end else if (cfg_index == CFG_NODATA) begin
        nodata_value <= cfg_data;
      end
    end
  end

  // The second stage moves on whenever the output register is empty or
  // being emptied; the input stalls when the second stage cannot move or the counter memory is still clearing.
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = !mem_ready || (s1_valid && !advance);
  assign accept   = in_valid && !in_stall;
  assign in_range = 32'(cell_index) < CELL_COUNT;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func     <= func;
      s1_addr     <= ADDR_W'(cell_index);
      s1_in_range <= in_range;
      s1_is_data  <= sample_is_data;
      s1_sample   <= sample_value;
    end
  end

  hac_count_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (ADDR_W'(cell_index)),
    .rd_data (mem_rd_data),
    .wr      (mem_wr),
    .ready   (mem_ready)
  );

  // Cells past the end of the map read as zero hits and are never counted.
  assign hits = s1_in_range ? mem_rd_data : '0;

  always_comb begin
    mem_wr.en   = advance && (s1_func == FUNC_ACCUM) && s1_is_data && s1_in_range;
    mem_wr.addr = s1_addr;
    mem_wr.data = (hits == '1) ? hits : hits + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_count <= '0;
    end else if (advance && (s1_func == FUNC_SCAN) && (scan_count != '1)) begin
      scan_count <= scan_count + 1'b1;
    end
  end

  hac_clutter_test u_test (
    .hits      (hits),
    .scans     (scan_count),
    .threshold (hit_threshold_q8),
    .is_data   (s1_is_data && (s1_func == FUNC_FILTER)),
    .clutter   (clutter)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_value     <= clutter ? nodata_value : s1_sample;
      removed       <= clutter;
      quality_value <= clutter ? s1_sample : '0;
    end
  end

  // A kept sample never carries a quality value.
  a_quality_only_when_removed: assert property (@(posedge clk) disable iff (rst)
    out_valid && !removed |-> quality_value == '0)
    else $error("quality value set on a kept sample");

  // The scan count only grows outside reset.
  a_scan_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> scan_count >= $past(scan_count))
    else $error("scan count decreased");

  // No counter write comes from the pipeline during the clearing sweep.
  a_no_write_while_clearing: assert property (@(posedge clk) disable iff (rst)
    !mem_ready |-> !mem_wr.en && !s1_valid)
    else $error("pipeline active during clearing sweep");

  // An item held in the second stage stays there until the output frees up.
  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_addr) && $stable(s1_func))
    else $error("second stage item lost while stalled");

endmodule
